[rtl/mrw_pkg.sv]
// shared constants, verdict codes and sequencer states for the witness test core
package mrw_pkg;

  localparam int NUM_BITS = 62;
  localparam int IN_W     = 62;
  localparam int CNT_W    = $clog2(NUM_BITS);
  localparam int S_W      = $clog2(NUM_BITS + 1);

  localparam logic [1:0] VERDICT_COMPOSITE   = 2'd0;
  localparam logic [1:0] VERDICT_PRIME       = 2'd1;
  localparam logic [1:0] VERDICT_BAD_MODULUS = 2'd2;
  localparam logic [1:0] VERDICT_BAD_WITNESS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_EXP_STEP,
    ST_WAIT_PMUL,
    ST_WAIT_BSQ,
    ST_TEST,
    ST_WAIT_SQR,
    ST_DONE
  } mrw_state_t;

endpackage

[rtl/mrw_modmul.sv]
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
module mrw_modmul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mrw_pkg::NUM_BITS-1:0] x,
  input  logic [mrw_pkg::NUM_BITS-1:0] y,
  input  logic [mrw_pkg::NUM_BITS-1:0] n,
  output logic                         done,
  output logic [mrw_pkg::NUM_BITS-1:0] result
);

  localparam int NB = mrw_pkg::NUM_BITS;

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [mrw_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NB-1:0]                 acc_r, acc_nxt;
  logic [NB-1:0]                 x_r, x_nxt;
  logic [NB-1:0]                 y_r, y_nxt;
  logic [NB-1:0]                 n_r, n_nxt;
  logic [NB+1:0]                 v, d1, d2, n1, n2;
  logic                          ge1, ge2;
  logic [NB-1:0]                 step_res;

  // acc*2 + bit*x lies below 3n, so at most two subtractions of n
  always_comb begin
    n1 = {2'b00, n_r};
    n2 = {1'b0, n_r, 1'b0};
    v  = {1'b0, acc_r, 1'b0} + (y_r[NB-1] ? {2'b00, x_r} : '0);
    d1 = v - n1;
    d2 = v - n2;
    ge1 = (v >= n1);
    ge2 = (v >= n2);
    if (ge2) begin
      step_res = d2[NB-1:0];
    end else if (ge1) begin
      step_res = d1[NB-1:0];
    end else begin
      step_res = v[NB-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    n_nxt    = n_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mrw_pkg::CNT_W'(NB - 1);
      acc_nxt  = '0;
      x_nxt    = x;
      y_nxt    = y;
      n_nxt    = n;
    end else if (busy_r) begin
      acc_nxt = step_res;
      y_nxt   = {y_r[NB-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    n_r   <= n_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

[rtl/miller_rabin_witness_test_core.sv]
// top level: one miller-rabin round with a single witness
// an invalid modulus or witness goes straight to the done state; otherwise the core splits
//   n-1 into d*2^s, runs square-and-multiply over the bits of d on the shared bit-serial
//   multiplier, then squares up to s-1 times for the witness test
// one request at a time: in_stall stays high until the core is back in idle
// reset: synchronous active-low rst_n clears the sequencer and the output valid
module miller_rabin_witness_test_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [mrw_pkg::IN_W-1:0] in_modulus,
  input  logic [mrw_pkg::IN_W-1:0] in_witness,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_verdict
);

  localparam int NB = mrw_pkg::NUM_BITS;

  mrw_pkg::mrw_state_t state_r, state_nxt;

  logic [NB-1:0]           n_r, n_nxt;
  logic [NB-1:0]           nm1_r, nm1_nxt;
  logic [NB-1:0]           d_r, d_nxt;
  logic [NB-1:0]           power_r, power_nxt;
  logic [NB-1:0]           base_r, base_nxt;
  logic [mrw_pkg::S_W-1:0] s_r, s_nxt;
  logic [mrw_pkg::S_W-1:0] round_r, round_nxt;
  logic [1:0]              verdict_r, verdict_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_verdict_r, out_verdict_nxt;

  logic [NB-1:0] in_n, in_a;
  logic          bad_mod, bad_wit, in_acc, out_free;
  logic          mul_start, mul_done;
  logic [NB-1:0] mul_x, mul_y, mul_res;
  logic [NB-1:0] one_v;

  assign one_v    = {{(NB-1){1'b0}}, 1'b1};
  assign in_n     = in_modulus[NB-1:0];
  assign in_a     = in_witness[NB-1:0];
  assign bad_mod  = (in_n < NB'(3)) || !in_n[0];
  assign bad_wit  = (in_a == '0) || (in_a >= in_n);
  assign in_stall = (state_r != mrw_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  mrw_modmul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .x      (mul_x),
    .y      (mul_y),
    .n      (n_r),
    .done   (mul_done),
    .result (mul_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (bad_mod || bad_wit) begin
            state_nxt = mrw_pkg::ST_DONE;
          end else begin
            state_nxt = mrw_pkg::ST_SPLIT;
          end
        end
      end
      mrw_pkg::ST_SPLIT: begin
        if (d_r[0]) begin
          state_nxt = mrw_pkg::ST_EXP_STEP;
        end
      end
      mrw_pkg::ST_EXP_STEP: begin
        if (d_r == '0) begin
          state_nxt = mrw_pkg::ST_TEST;
        end else if (d_r[0]) begin
          state_nxt = mrw_pkg::ST_WAIT_PMUL;
        end else begin
          state_nxt = mrw_pkg::ST_WAIT_BSQ;
        end
      end
      mrw_pkg::ST_WAIT_PMUL: begin
        if (mul_done) begin
          state_nxt = mrw_pkg::ST_WAIT_BSQ;
        end
      end
      mrw_pkg::ST_WAIT_BSQ: begin
        if (mul_done) begin
          state_nxt = mrw_pkg::ST_EXP_STEP;
        end
      end
      mrw_pkg::ST_TEST: begin
        if (power_r == one_v || power_r == nm1_r || s_r <= mrw_pkg::S_W'(1)) begin
          state_nxt = mrw_pkg::ST_DONE;
        end else begin
          state_nxt = mrw_pkg::ST_WAIT_SQR;
        end
      end
      mrw_pkg::ST_WAIT_SQR: begin
        if (mul_done && (mul_res == nm1_r || round_r + 1'b1 >= s_r)) begin
          state_nxt = mrw_pkg::ST_DONE;
        end
      end
      mrw_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = mrw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mrw_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt           = n_r;
    nm1_nxt         = nm1_r;
    d_nxt           = d_r;
    power_nxt       = power_r;
    base_nxt        = base_r;
    s_nxt           = s_r;
    round_nxt       = round_r;
    verdict_nxt     = verdict_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_verdict_nxt = out_verdict_r;
    mul_start       = 1'b0;
    mul_x           = power_r;
    mul_y           = base_r;
    case (state_r)
      mrw_pkg::ST_IDLE: begin
        if (in_acc) begin
          n_nxt     = in_n;
          nm1_nxt   = in_n - one_v;
          d_nxt     = in_n - one_v;
          power_nxt = one_v;
          base_nxt  = in_a;
          s_nxt     = '0;
          round_nxt = mrw_pkg::S_W'(1);
          if (bad_mod) begin
            verdict_nxt = mrw_pkg::VERDICT_BAD_MODULUS;
          end else if (bad_wit) begin
            verdict_nxt = mrw_pkg::VERDICT_BAD_WITNESS;
          end else begin
            verdict_nxt = mrw_pkg::VERDICT_COMPOSITE;
          end
        end
      end
      mrw_pkg::ST_SPLIT: begin
        if (!d_r[0]) begin
          d_nxt = {1'b0, d_r[NB-1:1]};
          s_nxt = s_r + 1'b1;
        end
      end
      mrw_pkg::ST_EXP_STEP: begin
        if (d_r != '0) begin
          mul_start = 1'b1;
          if (!d_r[0]) begin
            mul_x = base_r;
          end
        end
      end
      mrw_pkg::ST_WAIT_PMUL: begin
        mul_x = base_r;
        if (mul_done) begin
          power_nxt = mul_res;
          mul_start = 1'b1;
        end
      end
      mrw_pkg::ST_WAIT_BSQ: begin
        if (mul_done) begin
          base_nxt = mul_res;
          d_nxt    = {1'b0, d_r[NB-1:1]};
        end
      end
      mrw_pkg::ST_TEST: begin
        mul_y = power_r;
        if (power_r == one_v || power_r == nm1_r) begin
          verdict_nxt = mrw_pkg::VERDICT_PRIME;
        end else if (s_r > mrw_pkg::S_W'(1)) begin
          mul_start = 1'b1;
        end
      end
      mrw_pkg::ST_WAIT_SQR: begin
        mul_x = mul_res;
        mul_y = mul_res;
        if (mul_done) begin
          power_nxt = mul_res;
          round_nxt = round_r + 1'b1;
          if (mul_res == nm1_r) begin
            verdict_nxt = mrw_pkg::VERDICT_PRIME;
          end else if (round_r + 1'b1 < s_r) begin
            mul_start = 1'b1;
          end
        end
      end
      mrw_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = verdict_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r           <= n_nxt;
    nm1_r         <= nm1_nxt;
    d_r           <= d_nxt;
    power_r       <= power_nxt;
    base_r        <= base_nxt;
    s_r           <= s_nxt;
    round_r       <= round_nxt;
    verdict_r     <= verdict_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

[rtl/mrw_checker.sv]
// port-level checks for the witness test core, bound to the top level
module mrw_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [1:0]               out_verdict
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken while previous one in work");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict))
    else $error("stalled result changed");

endmodule

bind miller_rabin_witness_test_core mrw_checker u_mrw_checker (.*);

[bench/miller_rabin_witness_test_core_tb.sv]
// self-checking testbench for the miller-rabin single witness test core
`timescale 1ns / 1ps

module miller_rabin_witness_test_core_tb;

  localparam int          W          = mrw_pkg::IN_W;
  localparam logic [63:0] WORD_MASK  = (64'd1 << W) - 64'd1;
  localparam logic [63:0] WORK_MASK  = (64'd1 << mrw_pkg::NUM_BITS) - 64'd1;
  localparam int          CYCLE_LIMIT = 8_000_000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          RANDOM_REQUESTS = 71;

  localparam logic [63:0] KNOWN_MODULI [0:11] = '{
    64'd3, 64'd5, 64'd97, 64'd561, 64'd1105, 64'd2047, 64'd1373653, 64'd25326001,
    64'd3215031751, 64'd2147483647, 64'd2305843009213693951, 64'd4611686018427387847
  };

  typedef struct {
    logic [63:0] modulus;
    logic [63:0] witness;
    logic [1:0]  verdict;
  } pending_verdict_t;

  logic         clk;
  logic         rst_n       = 1'b0;
  logic         in_valid    = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_modulus  = '0;
  logic [W-1:0] in_witness  = '0;
  logic         out_valid;
  logic         out_stall   = 1'b0;
  logic [1:0]   out_verdict;

  pending_verdict_t pending_verdicts[$];
  int               mismatch_count = 0;
  int               cycle_count    = 0;
  int               stall_left     = 0;
  bit               no_idle        = 1'b0;

  miller_rabin_witness_test_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_modulus  (in_modulus),
    .in_witness  (in_witness),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] n);
    logic [63:0] acc;
    acc = 64'd0;
    for (int b = mrw_pkg::NUM_BITS - 1; b >= 0; b--) begin
      acc = acc << 1;
      if (acc >= n) acc = acc - n;
      if (y[b]) begin
        acc = acc + x;
        if (acc >= n) acc = acc - n;
      end
    end
    return acc;
  endfunction

  function automatic logic [1:0] witness_round_verdict(input logic [63:0] modulus,
                                                       input logic [63:0] witness);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] nm1;
    logic [63:0] d;
    logic [63:0] power;
    logic [63:0] base;
    int          s;
    n = modulus & WORK_MASK;
    a = witness & WORK_MASK;
    if (n < 64'd3 || !n[0]) return mrw_pkg::VERDICT_BAD_MODULUS;
    if (a == 64'd0 || a >= n) return mrw_pkg::VERDICT_BAD_WITNESS;
    nm1 = n - 64'd1;
    d = nm1;
    s = 0;
    while (!d[0] && s < 64) begin
      d = d >> 1;
      s++;
    end
    power = 64'd1;
    base = a;
    while (d != 64'd0) begin
      if (d[0]) power = mul_mod(power, base, n);
      base = mul_mod(base, base, n);
      d = d >> 1;
    end
    if (power == 64'd1 || power == nm1) return mrw_pkg::VERDICT_PRIME;
    for (int r = 1; r < s; r++) begin
      power = mul_mod(power, power, n);
      if (power == nm1) return mrw_pkg::VERDICT_PRIME;
    end
    return mrw_pkg::VERDICT_COMPOSITE;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom} & WORD_MASK;
  endfunction

  function automatic logic [63:0] rand_odd_modulus(input int len);
    logic [63:0] v;
    v = rand_word() & ((64'd1 << len) - 64'd1);
    v[len-1] = 1'b1;
    v[0] = 1'b1;
    return v;
  endfunction

  function automatic logic [63:0] in_range_witness(input logic [63:0] n);
    return 64'd1 + ({$urandom, $urandom} % (n - 64'd1));
  endfunction

  function automatic int rand_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(2, 20);
    if (r < 9) return $urandom_range(21, 40);
    return $urandom_range(41, mrw_pkg::NUM_BITS);
  endfunction

  task automatic send_request(input logic [63:0] modulus, input logic [63:0] witness);
    pending_verdict_t req;
    int               gap;
    req.modulus = modulus & WORD_MASK;
    req.witness = witness & WORD_MASK;
    req.verdict = witness_round_verdict(req.modulus, req.witness);
    gap = no_idle ? 0 : idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_modulus <= req.modulus[W-1:0];
    in_witness <= req.witness[W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(req);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic test_invalid_modulus();
    send_request(64'd0, 64'd1);
    send_request(64'd1, 64'd1);
    send_request(64'd2, 64'd1);
    send_request(64'd4, 64'd3);
    send_request(WORD_MASK - 64'd1, WORD_MASK);
    send_request(64'd0, 64'd0);
  endtask

  task automatic test_invalid_witness();
    send_request(64'd3, 64'd0);
    send_request(64'd3, 64'd3);
    send_request(64'd9, WORD_MASK);
    send_request(WORD_MASK, 64'd0);
  endtask

  task automatic test_trivial_witnesses();
    send_request(64'd221, 64'd1);
    send_request(64'd221, 64'd220);
    send_request(WORD_MASK, WORD_MASK - 64'd1);
    send_request(64'd3, 64'd1);
    send_request(64'd3, 64'd2);
  endtask

  task automatic test_known_numbers();
    send_request(64'd561, 64'd2);
    send_request(64'd2047, 64'd2);
    send_request(64'd3215031751, 64'd2);
    send_request(64'd2305843009213693951, 64'd3);
    send_request(WORD_MASK, 64'd2);
    send_request(64'd4611686018427387847, 64'd1234567890123456789);
  endtask

  task automatic test_back_to_back();
    logic [63:0] n;
    no_idle = 1'b1;
    for (int i = 0; i < 8; i++) begin
      n = rand_odd_modulus($urandom_range(2, 12));
      send_request(n, in_range_witness(n));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    logic [63:0] n;
    logic [63:0] a;
    int          k;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS / 2) wait_for_drain();
      k = $urandom_range(0, 99);
      if (k < 60) begin
        n = rand_odd_modulus(rand_length());
        a = in_range_witness(n);
      end else if (k < 72) begin
        n = KNOWN_MODULI[$urandom_range(0, 11)];
        a = $urandom_range(0, 1) ? 64'd2 : in_range_witness(n);
      end else if (k < 85) begin
        n = rand_word();
        a = rand_word();
      end else begin
        n = rand_odd_modulus($urandom_range(2, 20));
        a = in_range_witness(n);
        case ($urandom_range(0, 4))
          0: n[0] = 1'b0;
          1: n = 64'($urandom_range(0, 2));
          2: a = 64'd0;
          3: a = n;
          default: a = rand_word() | (64'd1 << (W - 1));
        endcase
      end
      send_request(n, a);
    end
  endtask

  // result checking and random output stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: verdict %0d with no request pending", out_verdict);
        end else if (out_verdict !== pending_verdicts[0].verdict) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("verdict mismatch: modulus %0d witness %0d expected %0d actual %0d",
                     pending_verdicts[0].modulus, pending_verdicts[0].witness,
                     pending_verdicts[0].verdict, out_verdict);
          void'(pending_verdicts.pop_front());
        end else begin
          void'(pending_verdicts.pop_front());
        end
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= idle_length();
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("miller_rabin_witness_test_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_invalid_modulus();
    test_invalid_witness();
    test_trivial_witnesses();
    test_known_numbers();
    test_back_to_back();
    test_random();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("miller_rabin_witness_test_core_tb: PASS");
    end else begin
      $display("miller_rabin_witness_test_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mrw_pkg.sv
rtl/mrw_modmul.sv
rtl/miller_rabin_witness_test_core.sv
rtl/mrw_checker.sv
bench/miller_rabin_witness_test_core_tb.sv
